/* rtl/fcp_pkg.sv */
// Shared constants, types and command codes for the framed command parser.
`default_nettype none

package fcp_pkg;

   // Frame buffer geometry.
   localparam int BufferDepth = 32;
   localparam int AddrWidth   = $clog2(BufferDepth);
   localparam int FillWidth   = $clog2(BufferDepth + 1);

   // Header and footer, first byte of the pattern in the lowest bits.
   localparam logic [31:0] HeaderBytes = 32'hFAFBFCFD;
   localparam logic [31:0] FooterBytes = 32'h01020304;

   // Fixed byte positions inside a frame.
   localparam int CmdLowIndex  = 6;
   localparam int CmdHighIndex = 7;
   localparam int ArgAIndex    = 8;
   localparam int ArgBIndex    = 9;
   localparam int ArgCIndex    = 10;

   // 16-bit little-endian command codes.
   localparam logic [15:0] CmdOpen        = 16'h00FF;
   localparam logic [15:0] CmdClose       = 16'h00FE;
   localparam logic [15:0] CmdSetRange    = 16'h0002;
   localparam logic [15:0] CmdSensitivity = 16'h0003;

   // Settings after reset.
   localparam logic [7:0] RangeReset       = 8'd100;
   localparam logic [7:0] DirectionReset   = 8'd1;
   localparam logic [7:0] SpeedReset       = 8'd5;
   localparam logic [7:0] SensitivityReset = 8'd5;

   typedef enum logic [2:0] {
      KindNone        = 3'd0,
      KindOpen        = 3'd1,
      KindClose       = 3'd2,
      KindRange       = 3'd3,
      KindSensitivity = 3'd4
   } kind_type;

   typedef struct packed {
      logic       frame_end;
      logic       header_ok;
      kind_type   command_kind;
      logic       applied;
      logic       config_open;
      logic [7:0] range_setting;
      logic [7:0] direction_setting;
      logic [7:0] speed_setting;
      logic [7:0] sensitivity_setting;
   } status_type;

endpackage

`default_nettype wire

/* rtl/fcp_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module fcp_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/fcp_parser.sv */
// Frame assembly, footer and header detection, command decode and settings.
`default_nettype none

module fcp_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        rx_byte,
   output fcp_pkg::status_type    status
);

   localparam int AW = fcp_pkg::AddrWidth;
   localparam int FW = fcp_pkg::FillWidth;

   logic [FW-1:0] fill_ff, fill_in;
   logic          hdr_ff, hdr_in;
   logic          mode_ff, mode_in;
   logic [7:0]    range_ff, range_in;
   logic [7:0]    direction_ff, direction_in;
   logic [7:0]    speed_ff, speed_in;
   logic [7:0]    sensitivity_ff, sensitivity_in;

   // Newest stored word is hist0.
   logic [7:0]    hist0_ff, hist1_ff, hist2_ff, hist3_ff;
   logic [7:0]    cmd_lo_ff, cmd_hi_ff, arg_a_ff, arg_c_ff;
   logic          pend_a_ff;

   logic          store;
   logic [AW-1:0] idx;
   logic [31:0]   window;
   logic          footer_hit;
   logic [7:0]    cmd_lo, cmd_hi;
   logic [15:0]   cmd;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;
   logic          frame_end, header_ok, applied;
   fcp_pkg::kind_type kind;

   assign store = accept && (fill_ff < FW'(fcp_pkg::BufferDepth));
   assign idx   = fill_ff[AW-1:0];

   // A full buffer keeps its last four words; otherwise the current word closes the window.
   assign window = store ? {rx_byte, hist0_ff, hist1_ff, hist2_ff}
                         : {hist0_ff, hist1_ff, hist2_ff, hist3_ff};
   assign footer_hit = accept && (window == fcp_pkg::FooterBytes)
                       && (!store || (fill_ff >= FW'(3)));

   // The command words may arrive in the very cycle the frame ends.
   assign cmd_lo = (store && idx == AW'(fcp_pkg::CmdLowIndex))  ? rx_byte : cmd_lo_ff;
   assign cmd_hi = (store && idx == AW'(fcp_pkg::CmdHighIndex)) ? rx_byte : cmd_hi_ff;
   assign cmd    = {cmd_hi, cmd_lo};

   // Argument words 8 and 9 are fetched back from the buffer while words 9 and 10
   // are written; a known command needs at least twelve words, so both are in
   // place before its footer completes.
   assign rd_en   = store && (idx == AW'(fcp_pkg::ArgBIndex) || idx == AW'(fcp_pkg::ArgCIndex));
   assign rd_addr = (idx == AW'(fcp_pkg::ArgBIndex)) ? AW'(fcp_pkg::ArgAIndex)
                                                    : AW'(fcp_pkg::ArgBIndex);

   fcp_ram #(
      .Width (8),
      .Depth (fcp_pkg::BufferDepth)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (idx),
      .wr_data (rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      fill_in        = fill_ff;
      hdr_in         = hdr_ff;
      mode_in        = mode_ff;
      range_in       = range_ff;
      direction_in   = direction_ff;
      speed_in       = speed_ff;
      sensitivity_in = sensitivity_ff;
      frame_end      = 1'b0;
      header_ok      = 1'b0;
      applied        = 1'b0;
      kind           = fcp_pkg::KindNone;

      if (store) begin
         fill_in = fill_ff + FW'(1);
         if (idx < AW'(4)) begin
            hdr_in = ((idx == '0) ? 1'b1 : hdr_ff)
                     & (rx_byte == fcp_pkg::HeaderBytes[8*idx[1:0] +: 8]);
         end
      end

      if (footer_hit) begin
         frame_end = 1'b1;
         fill_in   = '0;
         if (hdr_in) begin
            header_ok = 1'b1;
            unique case (cmd)
               fcp_pkg::CmdOpen: begin
                  kind    = fcp_pkg::KindOpen;
                  mode_in = 1'b1;
                  applied = 1'b1;
               end
               fcp_pkg::CmdClose: begin
                  kind    = fcp_pkg::KindClose;
                  mode_in = 1'b0;
                  applied = 1'b1;
               end
               fcp_pkg::CmdSetRange: begin
                  kind = fcp_pkg::KindRange;
                  if (mode_ff) begin
                     range_in     = arg_a_ff;
                     direction_in = rd_data;
                     speed_in     = arg_c_ff;
                     applied      = 1'b1;
                  end
               end
               fcp_pkg::CmdSensitivity: begin
                  kind = fcp_pkg::KindSensitivity;
                  if (mode_ff) begin
                     sensitivity_in = arg_a_ff;
                     applied        = 1'b1;
                  end
               end
               default: begin
                  kind = fcp_pkg::KindNone;
               end
            endcase
         end
      end
   end

   always_comb begin
      status.frame_end           = frame_end;
      status.header_ok           = header_ok;
      status.command_kind        = kind;
      status.applied             = applied;
      status.config_open         = mode_in;
      status.range_setting       = range_in;
      status.direction_setting   = direction_in;
      status.speed_setting       = speed_in;
      status.sensitivity_setting = sensitivity_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff        <= '0;
         mode_ff        <= 1'b0;
         range_ff       <= fcp_pkg::RangeReset;
         direction_ff   <= fcp_pkg::DirectionReset;
         speed_ff       <= fcp_pkg::SpeedReset;
         sensitivity_ff <= fcp_pkg::SensitivityReset;
         pend_a_ff      <= 1'b0;
      end else begin
         fill_ff        <= fill_in;
         mode_ff        <= mode_in;
         range_ff       <= range_in;
         direction_ff   <= direction_in;
         speed_ff       <= speed_in;
         sensitivity_ff <= sensitivity_in;
         pend_a_ff      <= store && (idx == AW'(fcp_pkg::ArgBIndex));
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
      if (store) begin
         hist0_ff <= rx_byte;
         hist1_ff <= hist0_ff;
         hist2_ff <= hist1_ff;
         hist3_ff <= hist2_ff;
      end
      if (store && idx == AW'(fcp_pkg::CmdLowIndex)) begin
         cmd_lo_ff <= rx_byte;
      end
      if (store && idx == AW'(fcp_pkg::CmdHighIndex)) begin
         cmd_hi_ff <= rx_byte;
      end
      if (store && idx == AW'(fcp_pkg::ArgCIndex)) begin
         arg_c_ff <= rx_byte;
      end
      if (pend_a_ff) begin
         arg_a_ff <= rd_data;
      end
   end

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(fcp_pkg::BufferDepth))
      else $error("fill count beyond buffer depth");

   assert property (@(posedge clock) disable iff (reset)
      accept && status.applied |-> status.frame_end && status.header_ok)
      else $error("command applied outside a complete headed frame");

   assert property (@(posedge clock) disable iff (reset)
      footer_hit |=> fill_ff == '0)
      else $error("fill count not cleared after frame end");
`endif

endmodule

`default_nettype wire

/* rtl/framed_command_parser_top.sv */
// Top level of the framed command parser: byte stream in, status stream out.
// Each accepted byte on the req_ side yields exactly one status word on the rsp_ side.
// The block takes one byte per clock cycle while req_tready is high. The status word
// of a byte comes from the combinational footer compare and command decode and is
// registered in the output stage; the frame buffer RAM takes one write per cycle.
// A two-entry output stage lets a byte be accepted while the previous status word
// still waits; req_tready drops only when both entries are full. The frame buffer
// holds BufferDepth bytes and needs no clearing after reset.
`default_nettype none

module framed_command_parser_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [0] config_open, [8:1] range_setting,
                                         // [16:9] direction_setting, [24:17] speed_setting,
                                         // [32:25] sensitivity_setting, [39:33] zero
   output logic             rsp_tlast,   // frame_end
   output logic [4:0]       rsp_tuser    // [0] header_ok, [3:1] command_kind, [4] applied
);

   logic                accept;
   logic                take;
   fcp_pkg::status_type status;

   logic                out_valid_ff, out_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   fcp_pkg::status_type out_ff, out_in;
   fcp_pkg::status_type skid_ff, skid_in;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign take       = out_valid_ff && rsp_tready;

   fcp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_tdata),
      .status  (status)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (take || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = status;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = status;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_ff.frame_end;
   assign rsp_tuser  = {out_ff.applied, out_ff.command_kind, out_ff.header_ok};
   assign rsp_tdata  = {7'd0,
                        out_ff.sensitivity_setting,
                        out_ff.speed_setting,
                        out_ff.direction_setting,
                        out_ff.range_setting,
                        out_ff.config_open};

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a word while the output entry is empty");

   assert property (@(posedge clock) disable iff (reset)
      accept && out_valid_ff && !rsp_tready |=> skid_valid_ff)
      else $error("word accepted during a stall was not parked in the skid entry");
`endif

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking bench for the framed command parser: directed and random byte streams.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 200000;
   localparam int PhaseBytes = 375;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic [4:0]  rsp_tuser;

   framed_command_parser_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // Bytes waiting to be driven and status words waiting to be received.
   logic [7:0] pending_bytes[$];
   fcp_pkg::status_type predicted_status[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   logic req_fire = 1'b0;

   int error_count   = 0;
   int status_seen   = 0;
   int bytes_in      = 0;
   int bytes_queued  = 0;
   int frames_ended  = 0;
   int header_frames = 0;
   int changes_made  = 0;
   int cycle_count   = 0;

   // Parser state as the bench expects it.
   logic [7:0] frame_copy[fcp_pkg::BufferDepth];
   int         frame_fill;
   logic       cfg_open;
   logic [7:0] range_now;
   logic [7:0] direction_now;
   logic [7:0] speed_now;
   logic [7:0] sensitivity_now;

   // Fill level and last four stored bytes as seen by the stimulus generator,
   // so that random traffic never jams the buffer before the final phase.
   int          gen_fill = 0;
   logic [31:0] gen_tail = '0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic reset_parser_model();
      foreach (frame_copy[k]) frame_copy[k] = 8'h00;
      frame_fill      = 0;
      cfg_open        = 1'b0;
      range_now       = fcp_pkg::RangeReset;
      direction_now   = fcp_pkg::DirectionReset;
      speed_now       = fcp_pkg::SpeedReset;
      sensitivity_now = fcp_pkg::SensitivityReset;
   endtask

   function automatic fcp_pkg::status_type parse_byte(logic [7:0] rx);
      fcp_pkg::status_type s;
      logic [15:0]         cmd;
      s = '0;
      if (frame_fill < fcp_pkg::BufferDepth) begin
         frame_copy[frame_fill] = rx;
         frame_fill++;
      end
      // A full buffer drops the byte but still looks for a footer at its end.
      if (frame_fill >= 4 &&
          {frame_copy[frame_fill-1], frame_copy[frame_fill-2],
           frame_copy[frame_fill-3], frame_copy[frame_fill-4]} == fcp_pkg::FooterBytes) begin
         s.frame_end = 1'b1;
         if ({frame_copy[3], frame_copy[2], frame_copy[1], frame_copy[0]}
             == fcp_pkg::HeaderBytes) begin
            s.header_ok = 1'b1;
            cmd = {frame_copy[fcp_pkg::CmdHighIndex], frame_copy[fcp_pkg::CmdLowIndex]};
            case (cmd)
               fcp_pkg::CmdOpen: begin
                  s.command_kind = fcp_pkg::KindOpen;
                  cfg_open = 1'b1;
                  s.applied = 1'b1;
               end
               fcp_pkg::CmdClose: begin
                  s.command_kind = fcp_pkg::KindClose;
                  cfg_open = 1'b0;
                  s.applied = 1'b1;
               end
               fcp_pkg::CmdSetRange: begin
                  s.command_kind = fcp_pkg::KindRange;
                  if (cfg_open) begin
                     range_now     = frame_copy[fcp_pkg::ArgAIndex];
                     direction_now = frame_copy[fcp_pkg::ArgBIndex];
                     speed_now     = frame_copy[fcp_pkg::ArgCIndex];
                     s.applied = 1'b1;
                  end
               end
               fcp_pkg::CmdSensitivity: begin
                  s.command_kind = fcp_pkg::KindSensitivity;
                  if (cfg_open) begin
                     sensitivity_now = frame_copy[fcp_pkg::ArgAIndex];
                     s.applied = 1'b1;
                  end
               end
               default: s.command_kind = fcp_pkg::KindNone;
            endcase
         end
         frame_fill = 0;
      end
      s.config_open         = cfg_open;
      s.range_setting       = range_now;
      s.direction_setting   = direction_now;
      s.speed_setting       = speed_now;
      s.sensitivity_setting = sensitivity_now;
      return s;
   endfunction

   task automatic report_error(string msg);
      error_count++;
      $display("ERROR at status word %0d: %s", status_seen, msg);
   endtask

   task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         report_error($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   // Stimulus generation.
   task automatic put_byte(logic [7:0] b);
      pending_bytes.push_back(b);
      bytes_queued++;
      if (gen_fill < fcp_pkg::BufferDepth) begin
         gen_fill++;
         gen_tail = {b, gen_tail[31:8]};
      end
      if (gen_fill >= 4 && gen_tail == fcp_pkg::FooterBytes) gen_fill = 0;
   endtask

   task automatic put_word(logic [31:0] w);
      for (int k = 0; k < 4; k++) put_byte(w[8*k +: 8]);
   endtask

   // Header, two free bytes and the command: the first eight bytes of a frame.
   task automatic put_head(logic [31:0] head, logic [15:0] filler, logic [15:0] cmd);
      put_word(head);
      put_byte(filler[7:0]);
      put_byte(filler[15:8]);
      put_byte(cmd[7:0]);
      put_byte(cmd[15:8]);
   endtask

   task automatic put_frame(bit keep_fill);
      int          n_args;
      int          n_pad;
      int          pick;
      logic [31:0] head;
      logic [15:0] cmd;
      n_args = ($urandom_range(9) < 2) ? $urandom_range(2) : 3;
      n_pad  = ($urandom_range(14) == 0) ? $urandom_range(20 - n_args) : $urandom_range(2);
      // A frame normally starts on an empty buffer; now and then it is appended
      // to leftover bytes so that the header lands out of place.
      if (!keep_fill || gen_fill + 12 + n_args + n_pad > fcp_pkg::BufferDepth) begin
         if (gen_fill != 0) put_word(fcp_pkg::FooterBytes);
      end
      head = fcp_pkg::HeaderBytes;
      if ($urandom_range(9) == 0) head = head ^ (32'd1 << $urandom_range(31));
      pick = $urandom_range(99);
      if (pick < 20)      cmd = fcp_pkg::CmdOpen;
      else if (pick < 30) cmd = fcp_pkg::CmdClose;
      else if (pick < 60) cmd = fcp_pkg::CmdSetRange;
      else if (pick < 85) cmd = fcp_pkg::CmdSensitivity;
      else if (pick < 93) cmd = {8'h00, 8'($urandom)};
      else                cmd = 16'($urandom);
      put_head(head, 16'($urandom), cmd);
      repeat (n_args + n_pad) put_byte(8'($urandom));
      put_word(fcp_pkg::FooterBytes);
   endtask

   task automatic put_noise();
      int n;
      int idx;
      n = $urandom_range(8, 1);
      repeat (n) begin
         if (gen_fill < 28) begin
            idx = $urandom_range(3);
            case ($urandom_range(3))
               0:       put_byte(fcp_pkg::FooterBytes[8*idx +: 8]);
               1:       put_byte(fcp_pkg::HeaderBytes[8*idx +: 8]);
               default: put_byte(8'($urandom));
            endcase
         end
      end
   endtask

   task automatic build_traffic(int count);
      int stop_at;
      stop_at = bytes_queued + count;
      while (bytes_queued < stop_at) begin
         if ($urandom_range(9) < 8) put_frame($urandom_range(9) == 0);
         else put_noise();
      end
      if (gen_fill != 0) put_word(fcp_pkg::FooterBytes);
   endtask

   // Ends the run: an open frame, a frame of the full buffer length, then a buffer filled
   // without a footer, after which every further byte is dropped for good.
   task automatic put_overflow_tail();
      put_head(fcp_pkg::HeaderBytes, 16'h0000, fcp_pkg::CmdOpen);
      put_word(fcp_pkg::FooterBytes);
      put_head(fcp_pkg::HeaderBytes, 16'hFF00, fcp_pkg::CmdSensitivity);
      put_byte(8'hFF);
      for (int k = 0; k < fcp_pkg::BufferDepth - 13; k++) put_byte(k[0] ? 8'h00 : 8'h80);
      put_word(fcp_pkg::FooterBytes);
      for (int k = 0; k < fcp_pkg::BufferDepth; k++) put_byte(8'h55 ^ k[7:0]);
      put_word(fcp_pkg::FooterBytes);
      put_byte(8'h00);
      put_byte(8'hFF);
      put_word(fcp_pkg::FooterBytes);
   endtask

   // Driver: one word on each channel side per falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_fire) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_bytes.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: predict on every accepted byte, check every accepted status word.
   always @(posedge clock) begin : monitor
      fcp_pkg::status_type want;
      req_fire <= req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predicted_status.push_back(parse_byte(req_tdata));
            bytes_in++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_status.size() == 0) begin
               report_error("status word arrived with no byte waiting for it");
            end else begin
               want = predicted_status.pop_front();
               compare_field("frame_end", rsp_tlast, want.frame_end);
               compare_field("header_ok", rsp_tuser[0], want.header_ok);
               compare_field("command_kind", rsp_tuser[3:1], want.command_kind);
               compare_field("applied", rsp_tuser[4], want.applied);
               compare_field("config_open", rsp_tdata[0], want.config_open);
               compare_field("range_setting", rsp_tdata[8:1], want.range_setting);
               compare_field("direction_setting", rsp_tdata[16:9], want.direction_setting);
               compare_field("speed_setting", rsp_tdata[24:17], want.speed_setting);
               compare_field("sensitivity_setting", rsp_tdata[32:25],
                             want.sensitivity_setting);
               compare_field("tdata padding", rsp_tdata[39:33], 8'h00);
               if (want.frame_end) frames_ended++;
               if (want.header_ok) header_frames++;
               if (want.applied) changes_made++;
            end
            status_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Timeout after %0d cycles with %0d status words outstanding",
                  cycle_count, predicted_status.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      reset_parser_model();
      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
         endcase
         if (phase == 0) begin
            // Set range while closed, with the footer over the argument bytes,
            // then an open command.
            put_head(fcp_pkg::HeaderBytes, 16'hFF00, fcp_pkg::CmdSetRange);
            put_word(fcp_pkg::FooterBytes);
            put_head(fcp_pkg::HeaderBytes, 16'h00FF, fcp_pkg::CmdOpen);
            put_word(fcp_pkg::FooterBytes);
         end
         build_traffic(PhaseBytes);
         if (phase == 3) put_overflow_tail();
         do @(posedge clock);
         while (pending_bytes.size() != 0 || req_tvalid || predicted_status.size() != 0);
      end
      repeat (8) @(posedge clock);
      $display("Checked %0d bytes and %0d status words: %0d frame ends, %0d with header,",
               bytes_in, status_seen, frames_ended, header_frames);
      $display("%0d settings or mode changes, under four idle patterns, ending on a jammed buffer.",
               changes_made);
      if (error_count == 0 && predicted_status.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
